FILE: rtl/core/tes_pkg.sv
// Shared types, constants and helpers of the tone event sequencer.
`default_nettype none

package tes_pkg;

    localparam int QUEUE_DEPTH   = 32;
    localparam int PTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int QUEUE_LEVEL_W = 6;
    localparam int TICK_W        = 16;
    localparam int DIV_W         = 16;

    localparam logic [TICK_W-1:0] MAX_TICKS_RESET = 16'd1000;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [DIV_W-1:0]  divisor;
        logic [TICK_W-1:0] ticks;
        logic              tone;
        logic              stop;
    } t_item;

    typedef struct packed {
        logic              stop;
        logic              tone;
        logic [TICK_W-1:0] dur;
        logic [DIV_W-1:0]  divisor;
    } t_entry;

    typedef struct packed {
        logic                     push_rejected;
        logic                     speaker_gate;
        logic [DIV_W-1:0]         tone_divisor;
        logic                     divisor_load;
        logic                     playing;
        logic [QUEUE_LEVEL_W-1:0] queue_level;
    } t_result;

    function automatic logic [TICK_W-1:0] clamp_ticks(input logic [TICK_W-1:0] t,
                                                      input logic [TICK_W-1:0] max_t);
        logic [TICK_W-1:0] hi;
        logic [TICK_W-1:0] lo;
        hi = (max_t == '0) ? TICK_W'(1) : max_t;
        lo = (t == '0) ? TICK_W'(1) : t;
        return (lo > hi) ? hi : lo;
    endfunction

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tes_queue_mem.sv
// Event queue storage: one write port, one registered read port.
`default_nettype none

module tes_queue_mem (
    input  wire                         i_clk,
    input  wire                         i_wr_en,
    input  wire  [tes_pkg::PTR_W-1:0]   i_wr_addr,
    input  tes_pkg::t_entry             i_wr_data,
    input  wire                         i_rd_en,
    input  wire  [tes_pkg::PTR_W-1:0]   i_rd_addr,
    output tes_pkg::t_entry             o_rd_data
);
    import tes_pkg::*;

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/core/tes_seq_unit.sv
// Sequencer state registers and the per-item update against the head entry.
`default_nettype none

module tes_seq_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_exec,
    input  tes_pkg::t_item              i_item,
    input  wire  [tes_pkg::TICK_W-1:0]  i_max_ticks,
    input  tes_pkg::t_entry             i_head,
    output logic                        o_wr_en,
    output logic [tes_pkg::PTR_W-1:0]   o_wr_addr,
    output tes_pkg::t_entry             o_wr_data,
    output logic [tes_pkg::PTR_W-1:0]   o_rd_addr,
    output tes_pkg::t_result            o_result
);
    import tes_pkg::*;

    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [LVL_W-1:0]  r_level, n_level;
    logic              r_active, n_active;
    logic              r_gate, n_gate;
    logic [DIV_W-1:0]  r_loaded, n_loaded;
    logic [TICK_W-1:0] r_cd, n_cd;
    logic              r_running, n_running;

    logic rejected;
    logic did_load;
    logic want_pop;
    logic flush;
    logic full;

    assign full = (r_level == LVL_W'(QUEUE_DEPTH));

    always_comb begin
        n_wr_ptr  = r_wr_ptr;
        n_rd_ptr  = r_rd_ptr;
        n_level   = r_level;
        n_active  = r_active;
        n_gate    = r_gate;
        n_loaded  = r_loaded;
        n_cd      = r_cd;
        n_running = r_running;
        rejected  = 1'b0;
        did_load  = 1'b0;
        want_pop  = 1'b0;
        flush     = 1'b0;
        o_wr_en   = 1'b0;

        unique case (i_item.op)
            OP_PUSH: begin
                if (full) begin
                    rejected = 1'b1;
                end else begin
                    o_wr_en  = 1'b1;
                    n_wr_ptr = next_ptr(r_wr_ptr);
                    n_level  = r_level + LVL_W'(1);
                end
            end
            OP_START: begin
                if (!r_active) begin
                    n_active = 1'b1;
                    want_pop = 1'b1;
                end
            end
            OP_STOP: begin
                flush = 1'b1;
            end
            OP_TICK: begin
                if (r_running) begin
                    n_cd = r_cd - TICK_W'(1);
                    if (n_cd == '0) begin
                        n_running = 1'b0;
                        want_pop  = r_active;
                    end
                end
            end
            default: begin
            end
        endcase

        // pop the head event; an empty queue or a stop event ends the sequence
        if (want_pop) begin
            if (r_level == '0) begin
                flush = 1'b1;
            end else begin
                n_rd_ptr = next_ptr(r_rd_ptr);
                n_level  = r_level - LVL_W'(1);
                if (i_head.stop) begin
                    flush = 1'b1;
                end else begin
                    if (i_head.tone && (i_head.divisor != '0)) begin
                        if (i_head.divisor != r_loaded) begin
                            n_loaded = i_head.divisor;
                            did_load = 1'b1;
                        end
                        n_gate = 1'b1;
                    end else begin
                        n_gate = 1'b0;
                    end
                    if (!n_running) begin
                        n_cd      = clamp_ticks(i_head.dur, i_max_ticks);
                        n_running = 1'b1;
                    end
                end
            end
        end

        if (flush) begin
            n_running = 1'b0;
            n_cd      = '0;
            n_wr_ptr  = '0;
            n_rd_ptr  = '0;
            n_level   = '0;
            n_active  = 1'b0;
            n_gate    = 1'b0;
            n_loaded  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_level   <= '0;
            r_active  <= 1'b0;
            r_gate    <= 1'b0;
            r_loaded  <= '0;
            r_cd      <= '0;
            r_running <= 1'b0;
        end else if (i_exec) begin
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_level   <= n_level;
            r_active  <= n_active;
            r_gate    <= n_gate;
            r_loaded  <= n_loaded;
            r_cd      <= n_cd;
            r_running <= n_running;
        end
    end

    assign o_wr_addr         = r_wr_ptr;
    assign o_wr_data.stop    = i_item.stop;
    assign o_wr_data.tone    = i_item.tone;
    assign o_wr_data.dur     = clamp_ticks(i_item.ticks, i_max_ticks);
    assign o_wr_data.divisor = i_item.divisor;
    assign o_rd_addr         = r_rd_ptr;

    assign o_result.push_rejected = rejected;
    assign o_result.speaker_gate  = n_gate;
    assign o_result.tone_divisor  = n_loaded;
    assign o_result.divisor_load  = did_load;
    assign o_result.playing       = n_active;
    assign o_result.queue_level   = QUEUE_LEVEL_W'(n_level);

endmodule

`default_nettype wire

FILE: rtl/core/tone_event_sequencer_core.sv
// Top level of the tone event sequencer: handshakes, config, result register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_op, i_event_* fields
//  out     | output    | o_out_valid / i_out_stall | o_push_rejected ... o_queue_level
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (max_ticks)
//
// Each item is handled in an accept cycle, which reads the queue head from the
// event memory, and an execute cycle, which updates the state and fills the result register.
// A new item is taken in the idle state once the result register is empty or drains in that cycle.
// Reset is synchronous; the queue memory needs no clearing, only its pointers and the state registers reset.
// A stalled result holds in the output register and blocks further items.
`default_nettype none

module tone_event_sequencer_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [1:0]                       i_op,
    input  wire  [tes_pkg::DIV_W-1:0]        i_event_divisor,
    input  wire  [tes_pkg::TICK_W-1:0]       i_event_ticks,
    input  wire                              i_event_tone,
    input  wire                              i_event_stop,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic                             o_push_rejected,
    output logic                             o_speaker_gate,
    output logic [tes_pkg::DIV_W-1:0]        o_tone_divisor,
    output logic                             o_divisor_load,
    output logic                             o_playing,
    output logic [tes_pkg::QUEUE_LEVEL_W-1:0] o_queue_level,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [tes_pkg::TICK_W-1:0]       i_cfg_data
);
    import tes_pkg::*;

    t_state            r_state, n_state;
    t_item             r_item;
    logic [TICK_W-1:0] r_max_ticks;
    logic              r_out_valid;
    t_result           r_out;

    logic              accept;
    logic              exec;
    logic              wr_en;
    logic              mem_wr;
    logic [PTR_W-1:0]  wr_addr;
    t_entry            wr_data;
    logic [PTR_W-1:0]  rd_addr;
    t_entry            head;
    t_result           result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        exec       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = r_out_valid && i_out_stall;
                if (i_in_valid && !o_in_stall) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                exec    = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign accept = i_in_valid && !o_in_stall;

    // capture the item; its queue read goes out in the same cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op      <= t_op'(i_op);
            r_item.divisor <= i_event_divisor;
            r_item.ticks   <= i_event_ticks;
            r_item.tone    <= i_event_tone;
            r_item.stop    <= i_event_stop;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ticks <= MAX_TICKS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_ticks <= i_cfg_data;
        end
    end

    tes_queue_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (head)
    );

    tes_seq_unit u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_exec      (exec),
        .i_item      (r_item),
        .i_max_ticks (r_max_ticks),
        .i_head      (head),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .o_result    (result)
    );

    // wr_en only counts in the execute cycle
    assign mem_wr = exec && wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_push_rejected = r_out.push_rejected;
    assign o_speaker_gate  = r_out.speaker_gate;
    assign o_tone_divisor  = r_out.tone_divisor;
    assign o_divisor_load  = r_out.divisor_load;
    assign o_playing       = r_out.playing;
    assign o_queue_level   = r_out.queue_level;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |-> !(r_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC) && !accept)
        else $error("accepted item not executed next cycle");

    a_write_only_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr |-> (r_item.op == OP_PUSH) && !result.push_rejected)
        else $error("queue written by a non-push item");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_playing) |-> (!o_speaker_gate && (o_tone_divisor == '0)))
        else $error("speaker active while sequencer stopped");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench of the tone event sequencer core, with its own sequencer predictor.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tes_pkg::*;

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_in_valid      = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_op            = '0;
    logic [DIV_W-1:0]         i_event_divisor = '0;
    logic [TICK_W-1:0]        i_event_ticks   = '0;
    logic                     i_event_tone    = 1'b0;
    logic                     i_event_stop    = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall     = 1'b0;
    logic                     o_push_rejected;
    logic                     o_speaker_gate;
    logic [DIV_W-1:0]         o_tone_divisor;
    logic                     o_divisor_load;
    logic                     o_playing;
    logic [QUEUE_LEVEL_W-1:0] o_queue_level;
    logic                     i_cfg_valid     = 1'b0;
    logic                     o_cfg_ready;
    logic [TICK_W-1:0]        i_cfg_data      = '0;

    tone_event_sequencer_core dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Predictor state: event ring, pointers and player status.
    logic [DIV_W-1:0]         ev_div  [QUEUE_DEPTH];
    logic [TICK_W-1:0]        ev_dur  [QUEUE_DEPTH];
    logic                     ev_tone [QUEUE_DEPTH];
    logic                     ev_stop [QUEUE_DEPTH];
    int unsigned              wr_idx      = 0;
    int unsigned              rd_idx      = 0;
    int unsigned              waiting     = 0;
    logic                     active_m    = 1'b0;
    logic                     gate_m      = 1'b0;
    logic [DIV_W-1:0]         carrier_m   = '0;
    logic [TICK_W-1:0]        countdown_m = '0;
    logic                     counting_m  = 1'b0;
    logic [TICK_W-1:0]        max_ticks_m = MAX_TICKS_RESET;
    logic                     reloaded_m  = 1'b0;

    t_item       queued_commands [$];
    t_result     expected_status [$];
    t_item       cur_cmd;
    int unsigned errors      = 0;
    int unsigned send_gap    = 0;
    int unsigned stall_left  = 0;
    logic        no_idle     = 1'b0;

    function automatic logic [TICK_W-1:0] limit_duration(input logic [TICK_W-1:0] t);
        logic [TICK_W-1:0] ceiling;
        ceiling = (max_ticks_m == 0) ? TICK_W'(1) : max_ticks_m;
        if (t == 0)
            t = TICK_W'(1);
        return (t > ceiling) ? ceiling : t;
    endfunction

    function automatic int unsigned ring_step(input int unsigned p);
        return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic void silence_all();
        counting_m  = 1'b0;
        countdown_m = '0;
        wr_idx      = 0;
        rd_idx      = 0;
        waiting     = 0;
        active_m    = 1'b0;
        gate_m      = 1'b0;
        carrier_m   = '0;
    endfunction

    function automatic void play_queue_head();
        logic [DIV_W-1:0]  d;
        logic [TICK_W-1:0] t;
        logic              tn;
        logic              sp;
        if (waiting == 0) begin
            silence_all();
            return;
        end
        d       = ev_div[rd_idx];
        t       = ev_dur[rd_idx];
        tn      = ev_tone[rd_idx];
        sp      = ev_stop[rd_idx];
        rd_idx  = ring_step(rd_idx);
        waiting = waiting - 1;
        if (sp) begin
            silence_all();
            return;
        end
        if (tn && d != 0) begin
            if (d != carrier_m) begin
                carrier_m  = d;
                reloaded_m = 1'b1;
            end
            gate_m = 1'b1;
        end else begin
            gate_m = 1'b0;
        end
        // a countdown still running keeps its count
        if (!counting_m) begin
            countdown_m = limit_duration(t);
            counting_m  = 1'b1;
        end
    endfunction

    function automatic t_result predict_status(input t_item it);
        t_result r;
        logic    rejected;
        rejected   = 1'b0;
        reloaded_m = 1'b0;
        case (it.op)
            OP_PUSH: begin
                if (waiting >= QUEUE_DEPTH) begin
                    rejected = 1'b1;
                end else begin
                    ev_div[wr_idx]  = it.divisor;
                    ev_dur[wr_idx]  = limit_duration(it.ticks);
                    ev_tone[wr_idx] = it.tone;
                    ev_stop[wr_idx] = it.stop;
                    wr_idx  = ring_step(wr_idx);
                    waiting = waiting + 1;
                end
            end
            OP_START: begin
                if (!active_m) begin
                    active_m = 1'b1;
                    play_queue_head();
                end
            end
            OP_STOP: silence_all();
            default: begin
                if (counting_m) begin
                    countdown_m = countdown_m - TICK_W'(1);
                    if (countdown_m == 0) begin
                        counting_m = 1'b0;
                        if (active_m)
                            play_queue_head();
                    end
                end
            end
        endcase
        r.push_rejected = rejected;
        r.speaker_gate  = gate_m;
        r.tone_divisor  = carrier_m;
        r.divisor_load  = reloaded_m;
        r.playing       = active_m;
        r.queue_level   = QUEUE_LEVEL_W'(waiting);
        return r;
    endfunction

    // Mostly no gap, some short ones, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : drive_items
        logic v;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            v = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_status.push_back(predict_status(cur_cmd));
                v = 1'b0;
            end
            if (!v) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (queued_commands.size() != 0) begin
                    cur_cmd = queued_commands.pop_front();
                    i_op            <= cur_cmd.op;
                    i_event_divisor <= cur_cmd.divisor;
                    i_event_ticks   <= cur_cmd.ticks;
                    i_event_tone    <= cur_cmd.tone;
                    i_event_stop    <= cur_cmd.stop;
                    v        = 1'b1;
                    send_gap = pick_gap();
                end
            end
            i_in_valid <= v;
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_result want;
        logic    s;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_status.size() == 0) begin
                    $display("%0t: result mismatch, expected none, actual rej %0b gate %0b div %0h",
                             $time, o_push_rejected, o_speaker_gate, o_tone_divisor);
                    errors++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("push_rejected", 16'(want.push_rejected), 16'(o_push_rejected));
                    check_field("speaker_gate", 16'(want.speaker_gate), 16'(o_speaker_gate));
                    check_field("tone_divisor", want.tone_divisor, o_tone_divisor);
                    check_field("divisor_load", 16'(want.divisor_load), 16'(o_divisor_load));
                    check_field("playing", 16'(want.playing), 16'(o_playing));
                    check_field("queue_level", 16'(want.queue_level), 16'(o_queue_level));
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                s = 1'b1;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
                s = (stall_left != 0);
            end else begin
                s = 1'b0;
            end
            i_out_stall <= s;
        end
    end

    int unsigned items_queued = 0;

    function automatic void add_item(input t_op op, input logic [DIV_W-1:0] d,
                                     input logic [TICK_W-1:0] t, input logic tn,
                                     input logic sp);
        t_item it;
        it.op      = op;
        it.divisor = d;
        it.ticks   = t;
        it.tone    = tn;
        it.stop    = sp;
        queued_commands.push_back(it);
        items_queued++;
    endfunction

    function automatic logic [TICK_W-1:0] pick_duration();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 82)
            return TICK_W'($urandom_range(1, 6));
        if (r < 92)
            return TICK_W'($urandom_range(0, 16'hFFFF));
        return 16'hFFFF;
    endfunction

    function automatic void add_random_event();
        logic [DIV_W-1:0] d;
        int unsigned      r;
        r = $urandom_range(0, 99);
        if (r < 40)
            d = 16'h0100 + DIV_W'($urandom_range(0, 2));
        else if (r < 50)
            d = '0;
        else
            d = DIV_W'($urandom_range(0, 16'hFFFF));
        add_item(OP_PUSH, d, pick_duration(), $urandom_range(0, 99) < 85,
                 $urandom_range(0, 99) < 6);
    endfunction

    function automatic void add_noise_item();
        add_item(t_op'($urandom_range(0, 3)), DIV_W'($urandom_range(0, 16'hFFFF)),
                 TICK_W'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    endfunction

    // Fill a batch of events, play it with ticks, sometimes cut it short.
    function automatic void add_sequence();
        int unsigned n;
        int unsigned ticks;
        if ($urandom_range(0, 99) < 10)
            n = $urandom_range(30, 36);
        else
            n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            add_random_event();
        if ($urandom_range(0, 99) < 85)
            add_item(OP_START, '0, '0, 1'b0, 1'b0);
        ticks = $urandom_range(0, n * 6 + 4);
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 19) == 0)
                add_noise_item();
            else if ($urandom_range(0, 29) == 0)
                add_random_event();
            else
                add_item(OP_TICK, '0, '0, 1'b0, 1'b0);
        end
        if ($urandom_range(0, 99) < 55)
            add_item(OP_STOP, '0, '0, 1'b0, 1'b0);
    endfunction

    task automatic fill_random(input int unsigned count);
        int unsigned stop_at;
        stop_at = items_queued + count;
        while (items_queued < stop_at)
            add_sequence();
    endtask

    task automatic wait_for_drain();
        while (queued_commands.size() != 0 || i_in_valid || expected_status.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_max_ticks(input logic [TICK_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        max_ticks_m = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : run_phases
        logic [TICK_W-1:0] limits [5];
        limits = '{16'd0, 16'hFFFF, 16'd8, TICK_W'($urandom_range(2, 20)), MAX_TICKS_RESET};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // arm one event at the reset clamp, tick part of it, then stop
        add_item(OP_PUSH, 16'h2345, 16'hFFFF, 1'b1, 1'b0);
        add_item(OP_PUSH, 16'h2345, 16'd5, 1'b1, 1'b0);
        add_item(OP_START, '0, '0, 1'b0, 1'b0);
        repeat (20) add_item(OP_TICK, '0, '0, 1'b0, 1'b0);
        add_item(OP_STOP, '0, '0, 1'b0, 1'b0);
        fill_random(80);
        wait_for_drain();

        write_max_ticks(16'd3);
        add_item(OP_TICK, '0, '0, 1'b0, 1'b0);
        add_item(OP_START, '0, '0, 1'b0, 1'b0);
        add_item(OP_PUSH, 16'h1234, 16'h0000, 1'b1, 1'b0);
        add_item(OP_PUSH, 16'h1234, 16'hFFFF, 1'b1, 1'b0);
        add_item(OP_PUSH, 16'hFFFF, 16'd2, 1'b0, 1'b0);
        add_item(OP_PUSH, 16'h0000, 16'd1, 1'b1, 1'b0);
        add_item(OP_PUSH, 16'hFFFF, 16'd3, 1'b1, 1'b0);
        add_item(OP_PUSH, 16'h5555, 16'd1, 1'b1, 1'b1);
        add_item(OP_START, '0, '0, 1'b0, 1'b0);
        add_item(OP_START, '0, '0, 1'b0, 1'b0);
        add_item(OP_PUSH, 16'h00AA, 16'd1, 1'b1, 1'b0);
        repeat (10) add_item(OP_TICK, '0, '0, 1'b0, 1'b0);
        add_item(OP_TICK, '0, '0, 1'b0, 1'b0);
        add_item(OP_PUSH, 16'h0F0F, 16'd4, 1'b1, 1'b0);
        add_item(OP_STOP, '0, '0, 1'b0, 1'b0);
        add_item(OP_START, '0, '0, 1'b0, 1'b0);
        wait_for_drain();

        // back-to-back stretch with no idling at the low clamp
        no_idle = 1'b1;
        write_max_ticks(16'd1);
        fill_random(80);
        wait_for_drain();
        no_idle = 1'b0;

        foreach (limits[i]) begin
            write_max_ticks(limits[i]);
            fill_random(80);
            wait_for_drain();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: tone_event_sequencer_core.f
rtl/core/tes_pkg.sv
rtl/core/tes_queue_mem.sv
rtl/core/tes_seq_unit.sv
rtl/core/tone_event_sequencer_core.sv
tb/tb.sv
